// ----- src/e2c_pkg.sv -----
// ----------------------------------------------------------------------------
// e2c_pkg
// Shared types and constants for the epoch seconds to calendar converter.
// ----------------------------------------------------------------------------
package e2c_pkg;

    localparam int unsigned IN_W    = 31;
    localparam int unsigned REM_W   = 17;
    localparam int unsigned DVD_W   = 15;
    localparam int unsigned STEP_W  = 4;
    localparam int unsigned DAYS_W  = 15;

    localparam logic [REM_W-1:0]  SECS_PER_DAY  = 17'd86400;
    localparam logic [REM_W-1:0]  SECS_PER_HOUR = 17'd3600;
    localparam logic [REM_W-1:0]  SECS_PER_MIN  = 17'd60;

    // quotient bits per division: days < 2^15, hours < 2^5, minutes < 2^6
    localparam logic [STEP_W-1:0] STEPS_DAY  = 4'd15;
    localparam logic [STEP_W-1:0] STEPS_HOUR = 4'd5;
    localparam logic [STEP_W-1:0] STEPS_MIN  = 4'd6;

    localparam logic [7:0] BASE_YEAR_OFS = 8'd70;
    localparam logic [2:0] EPOCH_WEEKDAY = 3'd4;
    localparam logic [3:0] MOD7          = 4'd7;
    localparam logic [3:0] LAST_MONTH    = 4'd11;
    localparam logic [3:0] MONTH_FEB     = 4'd1;

    localparam logic [4:0] MONTH_DAYS [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } e2c_div_ctrl_t;

    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        len = MONTH_DAYS[mon];
        if (leap && (mon == MONTH_FEB))
        begin
            len = 5'd29;
        end
        return len;
    endfunction

endpackage

// ----- src/e2c_divider.sv -----
// ----------------------------------------------------------------------------
// e2c_divider
// Bit-serial restoring divider, one quotient bit per cycle, with a running
// modulo-7 residue of the quotient bits.
// ----------------------------------------------------------------------------
module e2c_divider
    import e2c_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  e2c_div_ctrl_t             ctrl,
    input  logic [REM_W-1:0]          divisor,
    input  logic [REM_W-1:0]          init_rem,
    input  logic [DVD_W-1:0]          init_dvd,
    output logic                      busy,
    output logic [DVD_W-1:0]          quot,
    output logic [REM_W-1:0]          rem,
    output logic [2:0]                quot_mod7
);

    logic [REM_W-1:0]  rem_reg,  rem_next;
    logic [DVD_W-1:0]  dvd_reg,  dvd_next;
    logic [STEP_W-1:0] cnt_reg,  cnt_next;
    logic              busy_reg, busy_next;
    logic [2:0]        mod_reg,  mod_next;

    logic [REM_W:0]    trial;
    logic [REM_W:0]    diff;
    logic              ge;
    logic [3:0]        m2;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[DVD_W-1]};
        diff  = trial - {1'b0, divisor};
        ge    = (trial >= {1'b0, divisor});
        m2    = {mod_reg, ge};

        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        mod_next  = mod_reg;

        if (ctrl.start)
        begin
            rem_next  = init_rem;
            dvd_next  = init_dvd;
            cnt_next  = ctrl.steps;
            busy_next = 1'b1;
            mod_next  = 3'd0;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
            dvd_next  = {dvd_reg[DVD_W-2:0], ge};
            mod_next  = (m2 >= MOD7) ? 3'(m2 - MOD7) : m2[2:0];
            cnt_next  = cnt_reg - 4'd1;
            busy_next = (cnt_reg != 4'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            dvd_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            mod_reg  <= '0;
        end
        else
        begin
            rem_reg  <= rem_next;
            dvd_reg  <= dvd_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            mod_reg  <= mod_next;
        end
    end

    assign busy      = busy_reg;
    assign quot      = dvd_reg;
    assign rem       = rem_reg;
    assign quot_mod7 = mod_reg;

endmodule

// ----- src/e2c_calendar.sv -----
// ----------------------------------------------------------------------------
// e2c_calendar
// Splits a day count since 1970-01-01 into year, day of year, month and day
// of month, peeling one year and then one month per cycle.
// ----------------------------------------------------------------------------
module e2c_calendar
    import e2c_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DAYS_W-1:0]    days,
    output logic                 busy,
    output logic [7:0]           years_since_1900,
    output logic [8:0]           day_of_year,
    output logic [3:0]           month_index,
    output logic [4:0]           day_of_month
);

    typedef enum logic [1:0] {
        C_IDLE,
        C_YEAR,
        C_MONTH
    } cal_state_t;

    cal_state_t        state_reg, state_next;
    logic [DAYS_W-1:0] yday_reg,  yday_next;
    logic [7:0]        year_reg,  year_next;
    logic [3:0]        mon_reg,   mon_next;
    logic [8:0]        mday_reg,  mday_next;

    logic              leap;
    logic [8:0]        year_len;
    logic [4:0]        mon_len;

    // 1970..2038 only: every fourth year is leap (2000 included)
    assign leap     = (year_reg[1:0] == 2'b00);
    assign year_len = leap ? 9'd366 : 9'd365;
    assign mon_len  = month_len(mon_reg, leap);

    always_comb
    begin
        state_next = state_reg;
        yday_next  = yday_reg;
        year_next  = year_reg;
        mon_next   = mon_reg;
        mday_next  = mday_reg;

        case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    yday_next  = days;
                    year_next  = BASE_YEAR_OFS;
                    state_next = C_YEAR;
                end
            end
            C_YEAR:
            begin
                if (yday_reg < {6'd0, year_len})
                begin
                    mday_next  = yday_reg[8:0];
                    mon_next   = 4'd0;
                    state_next = C_MONTH;
                end
                else
                begin
                    yday_next = yday_reg - {6'd0, year_len};
                    year_next = year_reg + 8'd1;
                end
            end
            C_MONTH:
            begin
                if ((mon_reg == LAST_MONTH) || (mday_reg < {4'd0, mon_len}))
                begin
                    state_next = C_IDLE;
                end
                else
                begin
                    mday_next = mday_reg - {4'd0, mon_len};
                    mon_next  = mon_reg + 4'd1;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            yday_reg  <= '0;
            year_reg  <= '0;
            mon_reg   <= '0;
            mday_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            yday_reg  <= yday_next;
            year_reg  <= year_next;
            mon_reg   <= mon_next;
            mday_reg  <= mday_next;
        end
    end

    assign busy             = (state_reg != C_IDLE);
    assign years_since_1900 = year_reg;
    assign day_of_year      = yday_reg[8:0];
    assign month_index      = mon_reg;
    assign day_of_month     = mday_reg[4:0] + 5'd1;

endmodule

// ----- src/epoch_seconds_to_calendar_top.sv -----
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_top
// Seconds since 1970-01-01 00:00 UTC to broken-down UTC time.
//
//   channel  handshake           payload
//   input    in_valid/in_stall   epoch_seconds
//   output   out_valid/out_stall years_since_1900 .. second_of_minute
//
// One transfer in gives one transfer out. Day division runs first; the
// calendar peel (years past 1970, then months) then runs beside the hour
// and minute divisions.
// One item at a time; a held result does not block the next input transfer.
// Reset clears all control state; no clearing pass.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_top
    import e2c_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [IN_W-1:0]   epoch_seconds,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        years_since_1900,
    output logic [8:0]        day_of_year,
    output logic [3:0]        month_index,
    output logic [4:0]        day_of_month,
    output logic [2:0]        weekday,
    output logic [4:0]        hour_of_day,
    output logic [5:0]        minute_of_hour,
    output logic [5:0]        second_of_minute
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DAYS,
        ST_HOURS,
        ST_MINS,
        ST_FINISH
    } state_t;

    state_t           state_reg, state_next;
    logic [2:0]       wday_reg,  wday_next;
    logic [4:0]       hour_reg,  hour_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       year_o_reg,  year_o_next;
    logic [8:0]       yday_o_reg,  yday_o_next;
    logic [3:0]       mon_o_reg,   mon_o_next;
    logic [4:0]       mday_o_reg,  mday_o_next;
    logic [2:0]       wday_o_reg,  wday_o_next;
    logic [4:0]       hour_o_reg,  hour_o_next;
    logic [5:0]       min_o_reg,   min_o_next;
    logic [5:0]       sec_o_reg,   sec_o_next;

    e2c_div_ctrl_t    div_ctrl;
    logic [REM_W-1:0] div_divisor;
    logic [REM_W-1:0] div_init_rem;
    logic [DVD_W-1:0] div_init_dvd;
    logic             div_busy;
    logic [DVD_W-1:0] div_quot;
    logic [REM_W-1:0] div_rem;
    logic [2:0]       div_mod7;

    logic             cal_start;
    logic             cal_busy;
    logic [7:0]       cal_year;
    logic [8:0]       cal_yday;
    logic [3:0]       cal_mon;
    logic [4:0]       cal_mday;

    logic             slot_free;
    logic [3:0]       wsum;

    e2c_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .divisor   (div_divisor),
        .init_rem  (div_init_rem),
        .init_dvd  (div_init_dvd),
        .busy      (div_busy),
        .quot      (div_quot),
        .rem       (div_rem),
        .quot_mod7 (div_mod7)
    );

    e2c_calendar u_cal (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (cal_start),
        .days             (div_quot),
        .busy             (cal_busy),
        .years_since_1900 (cal_year),
        .day_of_year      (cal_yday),
        .month_index      (cal_mon),
        .day_of_month     (cal_mday)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign slot_free = !out_valid_reg || !out_stall;
    assign wsum      = {1'b0, div_mod7} + {1'b0, EPOCH_WEEKDAY};

    always_comb
    begin
        state_next     = state_reg;
        wday_next      = wday_reg;
        hour_next      = hour_reg;
        out_valid_next = out_valid_reg && out_stall;
        year_o_next    = year_o_reg;
        yday_o_next    = yday_o_reg;
        mon_o_next     = mon_o_reg;
        mday_o_next    = mday_o_reg;
        wday_o_next    = wday_o_reg;
        hour_o_next    = hour_o_reg;
        min_o_next     = min_o_reg;
        sec_o_next     = sec_o_reg;

        div_ctrl.start = 1'b0;
        div_ctrl.steps = STEPS_DAY;
        div_divisor    = SECS_PER_DAY;
        div_init_rem   = {1'b0, epoch_seconds[IN_W-1:DVD_W]};
        div_init_dvd   = epoch_seconds[DVD_W-1:0];
        cal_start      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    div_ctrl.start = 1'b1;
                    state_next     = ST_DAYS;
                end
            end
            ST_DAYS:
            begin
                div_divisor = SECS_PER_DAY;
                if (!div_busy)
                begin
                    div_ctrl.start = 1'b1;
                    div_ctrl.steps = STEPS_HOUR;
                    div_divisor    = SECS_PER_HOUR;
                    div_init_rem   = {5'd0, div_rem[REM_W-1:5]};
                    div_init_dvd   = {div_rem[4:0], 10'd0};
                    cal_start      = 1'b1;
                    wday_next      = (wsum >= MOD7) ? 3'(wsum - MOD7) : wsum[2:0];
                    state_next     = ST_HOURS;
                end
            end
            ST_HOURS:
            begin
                div_divisor = SECS_PER_HOUR;
                if (!div_busy)
                begin
                    hour_next      = div_quot[4:0];
                    div_ctrl.start = 1'b1;
                    div_ctrl.steps = STEPS_MIN;
                    div_divisor    = SECS_PER_MIN;
                    div_init_rem   = {11'd0, div_rem[11:6]};
                    div_init_dvd   = {div_rem[5:0], 9'd0};
                    state_next     = ST_MINS;
                end
            end
            ST_MINS:
            begin
                div_divisor = SECS_PER_MIN;
                if (!div_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                div_divisor = SECS_PER_MIN;
                if (!cal_busy && slot_free)
                begin
                    out_valid_next = 1'b1;
                    year_o_next    = cal_year;
                    yday_o_next    = cal_yday;
                    mon_o_next     = cal_mon;
                    mday_o_next    = cal_mday;
                    wday_o_next    = wday_reg;
                    hour_o_next    = hour_reg;
                    min_o_next     = div_quot[5:0];
                    sec_o_next     = div_rem[5:0];
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wday_reg      <= '0;
            hour_reg      <= '0;
            out_valid_reg <= 1'b0;
            year_o_reg    <= '0;
            yday_o_reg    <= '0;
            mon_o_reg     <= '0;
            mday_o_reg    <= '0;
            wday_o_reg    <= '0;
            hour_o_reg    <= '0;
            min_o_reg     <= '0;
            sec_o_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            wday_reg      <= wday_next;
            hour_reg      <= hour_next;
            out_valid_reg <= out_valid_next;
            year_o_reg    <= year_o_next;
            yday_o_reg    <= yday_o_next;
            mon_o_reg     <= mon_o_next;
            mday_o_reg    <= mday_o_next;
            wday_o_reg    <= wday_o_next;
            hour_o_reg    <= hour_o_next;
            min_o_reg     <= min_o_next;
            sec_o_reg     <= sec_o_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign years_since_1900 = year_o_reg;
    assign day_of_year      = yday_o_reg;
    assign month_index      = mon_o_reg;
    assign day_of_month     = mday_o_reg;
    assign weekday          = wday_o_reg;
    assign hour_of_day      = hour_o_reg;
    assign minute_of_hour   = min_o_reg;
    assign second_of_minute = sec_o_reg;

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_ctrl.start |-> !div_busy)
        else $error("divider restarted while busy");

    a_cal_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cal_start |-> !cal_busy)
        else $error("calendar restarted while busy");

    a_finish_issues: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) && !cal_busy && slot_free |=> out_valid)
        else $error("finished item not presented");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hour_of_day < 5'd24) && (minute_of_hour < 6'd60)
                      && (second_of_minute < 6'd60) && (weekday < 3'd7))
        else $error("time of day out of range");

    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (month_index < 4'd12) && (day_of_month != 5'd0)
                      && (day_of_year <= 9'd365))
        else $error("date out of range");

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for epoch_seconds_to_calendar_top. A queue-fed driver
// sends second counts, each transfer in is converted to UTC calendar fields
// by a local predictor, and a monitor compares every output transfer with
// the oldest prediction. Directed edge dates come first, then random counts
// (uniform, near year boundaries and small) under four idle/stall phases.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import e2c_pkg::*;

    localparam int unsigned MAX_SECONDS   = 32'h7FFF_FFFF;
    localparam int unsigned DAY_SECONDS   = 86400;
    localparam int unsigned HOUR_SECONDS  = 3600;
    localparam int unsigned MIN_SECONDS   = 60;
    localparam int unsigned FIRST_YEAR    = 1970;
    localparam int unsigned YEAR_BIAS     = 1900;
    localparam int unsigned THURSDAY      = 4;
    localparam int unsigned ITEMS_PER_RUN = 325;
    localparam int unsigned HANG_LIMIT    = 5000;
    localparam int unsigned DRAIN_CYCLES  = 150;

    typedef struct packed {
        logic [7:0] year;
        logic [8:0] yday;
        logic [3:0] mon;
        logic [4:0] mday;
        logic [2:0] wday;
        logic [4:0] hour;
        logic [5:0] mins;
        logic [5:0] secs;
    } calendar_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            in_valid = 1'b0;
    logic            in_stall;
    logic [IN_W-1:0] epoch_seconds = '0;
    logic            out_valid;
    logic            out_stall = 1'b0;
    logic [7:0]      years_since_1900;
    logic [8:0]      day_of_year;
    logic [3:0]      month_index;
    logic [4:0]      day_of_month;
    logic [2:0]      weekday;
    logic [4:0]      hour_of_day;
    logic [5:0]      minute_of_hour;
    logic [5:0]      second_of_minute;

    logic [IN_W-1:0] pending_secs [$];
    calendar_t       calendar_q [$];
    int unsigned     idle_pct = 0;
    int unsigned     stall_pct = 0;
    int unsigned     failures = 0;
    int unsigned     quiet_cycles = 0;

    epoch_seconds_to_calendar_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .epoch_seconds    (epoch_seconds),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .years_since_1900 (years_since_1900),
        .day_of_year      (day_of_year),
        .month_index      (month_index),
        .day_of_month     (day_of_month),
        .weekday          (weekday),
        .hour_of_day      (hour_of_day),
        .minute_of_hour   (minute_of_hour),
        .second_of_minute (second_of_minute)
    );

    always #4 clk = ~clk;

    function automatic bit is_leap(input int unsigned yr);
        return ((yr % 4) == 0) && (((yr % 100) != 0) || ((yr % 400) == 0));
    endfunction

    function automatic calendar_t to_calendar(input logic [IN_W-1:0] count);
        int unsigned days;
        int unsigned rest;
        int unsigned yr;
        int unsigned yday;
        int unsigned ylen;
        int unsigned mon;
        int unsigned mday;
        int unsigned mlen;
        calendar_t   c;
        days = count / DAY_SECONDS;
        rest = count % DAY_SECONDS;
        yr   = FIRST_YEAR;
        yday = days;
        ylen = is_leap(yr) ? 366 : 365;
        while (yday >= ylen)
        begin
            yday -= ylen;
            yr++;
            ylen = is_leap(yr) ? 366 : 365;
        end
        mon  = 0;
        mday = yday;
        while (mon < 11)
        begin
            case (mon)
                1:          mlen = is_leap(yr) ? 29 : 28;
                3, 5, 8, 10: mlen = 30;
                default:    mlen = 31;
            endcase
            if (mday < mlen)
            begin
                break;
            end
            mday -= mlen;
            mon++;
        end
        c.year = 8'(yr - YEAR_BIAS);
        c.yday = 9'(yday);
        c.mon  = 4'(mon);
        c.mday = 5'(mday + 1);
        c.wday = 3'((days + THURSDAY) % 7);
        c.hour = 5'(rest / HOUR_SECONDS);
        c.mins = 6'((rest % HOUR_SECONDS) / MIN_SECONDS);
        c.secs = 6'(rest % MIN_SECONDS);
        return c;
    endfunction

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            failures++;
        end
    endtask

    // sender pauses until every outstanding result has come back
    task automatic drain();
        while (pending_secs.size() != 0 || in_valid || calendar_q.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic run_phase(input int unsigned idle, input int unsigned stall);
        int unsigned yr;
        int unsigned y;
        longint      day_count;
        longint      value;
        @(negedge clk);
        idle_pct  = idle;
        stall_pct = stall;
        repeat (ITEMS_PER_RUN)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    value = $urandom() & MAX_SECONDS;
                end
                6, 7, 8:
                begin
                    yr = $urandom_range(1971, 2037);
                    day_count = 0;
                    for (y = FIRST_YEAR; y < yr; y++)
                    begin
                        day_count += is_leap(y) ? 366 : 365;
                    end
                    case ($urandom_range(0, 5))
                        0:       day_count -= 1;
                        1:       day_count += 0;
                        2:       day_count += 58;
                        3:       day_count += 59;
                        4:       day_count += 364;
                        default: day_count += 365;
                    endcase
                    value = day_count * DAY_SECONDS + $urandom_range(0, DAY_SECONDS - 1);
                    if (value > MAX_SECONDS)
                    begin
                        value = MAX_SECONDS;
                    end
                end
                default:
                begin
                    value = $urandom_range(0, 3 * DAY_SECONDS);
                end
            endcase
            pending_secs.push_back(IN_W'(value));
        end
        drain();
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                calendar_q.push_back(to_calendar(epoch_seconds));
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_secs.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    in_valid      <= 1'b1;
                    epoch_seconds <= pending_secs.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        calendar_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (calendar_q.size() == 0)
                begin
                    $error("output transfer with no result expected");
                    failures++;
                end
                else
                begin
                    want = calendar_q.pop_front();
                    check_field("years_since_1900", want.year, years_since_1900);
                    check_field("day_of_year", want.yday, day_of_year);
                    check_field("month_index", want.mon, month_index);
                    check_field("day_of_month", want.mday, day_of_month);
                    check_field("weekday", want.wday, weekday);
                    check_field("hour_of_day", want.hour, hour_of_day);
                    check_field("minute_of_hour", want.mins, minute_of_hour);
                    check_field("second_of_minute", want.secs, second_of_minute);
                end
            end
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == HANG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, year ends, leap days, century leap year
        pending_secs.push_back(31'd0);
        pending_secs.push_back(31'd59);
        pending_secs.push_back(31'd60);
        pending_secs.push_back(31'd3599);
        pending_secs.push_back(31'd3600);
        pending_secs.push_back(31'd86399);
        pending_secs.push_back(31'd86400);
        pending_secs.push_back(31'd2678399);
        pending_secs.push_back(31'd31535999);
        pending_secs.push_back(31'd31536000);
        pending_secs.push_back(31'd68083200);
        pending_secs.push_back(31'd68169600);
        pending_secs.push_back(31'd68255999);
        pending_secs.push_back(31'd94608000);
        pending_secs.push_back(31'd94694399);
        pending_secs.push_back(31'd946684800);
        pending_secs.push_back(31'd951782400);
        pending_secs.push_back(31'd978220800);
        pending_secs.push_back(31'd978307199);
        pending_secs.push_back(31'd1356998399);
        pending_secs.push_back(31'd2145916799);
        pending_secs.push_back(31'd2145916800);
        pending_secs.push_back(31'h7FFF_FFFF);
        pending_secs.push_back(31'h5555_5555);
        pending_secs.push_back(31'h2AAA_AAAA);
        drain();

        run_phase(0, 0);
        run_phase(46, 0);
        run_phase(0, 46);
        run_phase(21, 21);

        @(negedge clk);
        stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
